### hdl/foc_current_loop_two_phase_unit_macros.svh
// assertion macros shared by the checker
`ifndef FOC_CURRENT_LOOP_TWO_PHASE_UNIT_MACROS_SVH
`define FOC_CURRENT_LOOP_TWO_PHASE_UNIT_MACROS_SVH

// checked only outside reset
`define FOC_CL_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("foc current loop check failed");

// checked in every cycle, reset included
`define FOC_CL_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("foc current loop check failed");

`endif

### hdl/foc_cl_pkg.sv
`timescale 1ns / 1ps

package foc_cl_pkg;

  typedef struct packed {
    logic signed [31:0] phase_a_current;
    logic signed [31:0] phase_b_current;
    logic [15:0]        elec_angle;
    logic signed [31:0] d_setpoint;
    logic signed [31:0] q_setpoint;
  } sample_t;

  typedef struct packed {
    logic [15:0]        duty_a;
    logic [15:0]        duty_b;
    logic signed [31:0] volt_d;
    logic signed [31:0] volt_q;
  } result_t;

  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PROP_GAIN       = 3'd0,
    CFG_INTEGRAL_RATIO  = 3'd1,
    CFG_ANTIWINDUP_GAIN = 3'd2,
    CFG_VOLT_UPPER      = 3'd3,
    CFG_VOLT_LOWER      = 3'd4,
    CFG_INV_SUPPLY_VOLT = 3'd5,
    CFG_DUTY_FULL       = 3'd6
  } cfg_index_t;

  localparam logic [30:0]        PROP_GAIN_RST       = 31'd65536;
  localparam logic [30:0]        INTEGRAL_RATIO_RST  = 31'd546;
  localparam logic [30:0]        ANTIWINDUP_GAIN_RST = 31'd65536;
  localparam logic signed [31:0] VOLT_UPPER_RST      = 32'sd1572864;
  localparam logic signed [31:0] VOLT_LOWER_RST      = -32'sd1572864;
  localparam logic [30:0]        INV_SUPPLY_VOLT_RST = 31'd2731;
  localparam logic [15:0]        DUTY_FULL_RST       = 16'd4200;

  localparam int MUL_A_W    = 33;
  localparam int MUL_B_W    = 32;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int TRIG_MAG_W = 17;
  localparam int TRIG_W     = TRIG_MAG_W + 1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ROM_SIN,
    ST_ROM_COS,
    ST_TRIG,
    ST_ID_A,
    ST_ID_B,
    ST_IQ_A,
    ST_IQ_B,
    ST_ES_D,
    ST_ES_Q,
    ST_INT_D,
    ST_INT_Q,
    ST_PROP_D,
    ST_PROP_Q,
    ST_VA_A,
    ST_VA_B,
    ST_VB_A,
    ST_VB_B,
    ST_TA,
    ST_TB,
    ST_DA,
    ST_DB,
    ST_DONE
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(64'sd2147483647)) begin
      return 32'sh7FFFFFFF;
    end else if (v < SUM_W'(-64'sd2147483648)) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [31:0] clamp(input logic signed [31:0] u,
                                               input logic signed [31:0] hi,
                                               input logic signed [31:0] lo);
    if (u > hi) begin
      return hi;
    end else if (u < lo) begin
      return lo;
    end else begin
      return u;
    end
  endfunction

  function automatic logic [15:0] to_duty(input logic signed [PROD_W-1:0] w,
                                          input logic [15:0] full);
    logic [PROD_W-18:0] d;
    d = w[PROD_W-1:17];
    if (w < 0) begin
      return 16'd0;
    end else if (d > (PROD_W-17)'(full)) begin
      return full;
    end else begin
      return d[15:0];
    end
  endfunction

  // quarter-wave sine entry, Q16, for offset m of a table with 2^bits entries
  function automatic logic [TRIG_MAG_W-1:0] quarter_sine(input int unsigned m,
                                                         input int bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = (64'd3373259426 * 64'(m)) >> (bits - 1);
    x2 = (x * x) >> 30;
    t  = 64'd1073741824;
    t  = 64'd1073741824 - (((x2 * t) >> 30) / 64'd156);
    t  = 64'd1073741824 - (((x2 * t) >> 30) / 64'd110);
    t  = 64'd1073741824 - (((x2 * t) >> 30) / 64'd72);
    t  = 64'd1073741824 - (((x2 * t) >> 30) / 64'd42);
    t  = 64'd1073741824 - (((x2 * t) >> 30) / 64'd20);
    t  = 64'd1073741824 - (((x2 * t) >> 30) / 64'd6);
    return TRIG_MAG_W'((((x * t) >> 30) + 64'd8192) >> 14);
  endfunction

endpackage

### hdl/foc_cl_sine_rom.sv
`timescale 1ns / 1ps

module foc_cl_sine_rom #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                                      clk,
  input  logic [SINE_TABLE_BITS-1:0]                index,
  output logic signed [foc_cl_pkg::TRIG_W-1:0]      value
);

  localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
  localparam int DEPTH   = QUARTER + 1;
  localparam int AW      = SINE_TABLE_BITS - 1;

  typedef logic [foc_cl_pkg::TRIG_MAG_W-1:0] rom_t [DEPTH];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < DEPTH; i++) begin
      r[i] = foc_cl_pkg::quarter_sine(i, SINE_TABLE_BITS);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [1:0]                          quad;
  logic [AW-1:0]                       offs;
  logic [AW-1:0]                       addr;
  logic [foc_cl_pkg::TRIG_MAG_W-1:0]   mag;
  logic                                neg;

  // quadrant folding onto the quarter wave
  always_comb begin
    quad = index[SINE_TABLE_BITS-1 -: 2];
    offs = {1'b0, index[SINE_TABLE_BITS-3:0]};
    addr = quad[0] ? AW'(QUARTER) - offs : offs;
  end

  always_ff @(posedge clk) begin
    mag <= ROM[addr];
    neg <= quad[1];
  end

  assign value = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

### hdl/foc_cl_mul.sv
`timescale 1ns / 1ps

module foc_cl_mul (
  input  logic                                    clk,
  input  logic signed [foc_cl_pkg::MUL_A_W-1:0]   a,
  input  logic signed [foc_cl_pkg::MUL_B_W-1:0]   b,
  output logic signed [foc_cl_pkg::PROD_W-1:0]    prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

### hdl/foc_current_loop_two_phase_unit.sv
`timescale 1ns / 1ps

// Two-phase field-oriented current loop: Park transform, d and q PI regulators
// with back-calculation anti-windup and clamping, inverse Park, PWM duties.
// Input channel sample/sample_valid/sample_ready carries one control period
// per transaction; output channel result/result_valid/result_ready returns
// one transaction per sample with both duties and the clamped d/q voltages.
// Configuration is written through cfg_write/cfg_index/cfg_data; the user must
// write it only while idle, as the block itself does not enforce this.
// After two sine table reads the sequencer drives one 33x32 multiplier
// per cycle through 18 products, so the block holds one sample at a time;
// sample_ready is high only between samples.
// The result sits in an output register; a stalled receiver holds the last
// step of the next sample until the previous result is taken.
// Reset clears the regulator history to zero, loads default gains, clamps,
// supply reciprocal and full-scale duty, and drops result_valid.

module foc_current_loop_two_phase_unit #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        sample_valid,
  output logic                                        sample_ready,
  input  foc_cl_pkg::sample_t                         sample,
  output logic                                        result_valid,
  input  logic                                        result_ready,
  output foc_cl_pkg::result_t                         result,
  input  logic                                        cfg_write,
  input  logic [foc_cl_pkg::CFG_INDEX_W-1:0]          cfg_index,
  input  logic [31:0]                                 cfg_data
);

  localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
  localparam int AW      = foc_cl_pkg::MUL_A_W;
  localparam int BW      = foc_cl_pkg::MUL_B_W;
  localparam int SW      = foc_cl_pkg::SUM_W;

  foc_cl_pkg::state_t state, state_next;

  logic [30:0]        prop_gain, integral_ratio, antiwindup_gain, inv_supply_volt;
  logic signed [31:0] volt_upper, volt_lower;
  logic [15:0]        duty_full;

  logic signed [31:0] d_prev_error, d_prev_corr_error, d_prev_raw_out, d_prev_clamped_out;
  logic signed [31:0] q_prev_error, q_prev_corr_error, q_prev_raw_out, q_prev_clamped_out;

  foc_cl_pkg::sample_t smp;
  logic signed [foc_cl_pkg::TRIG_W-1:0] sin_v, cos_v, rom_value;
  logic [SINE_TABLE_BITS-1:0] angle_idx, rom_index;

  logic signed [foc_cl_pkg::PROD_W-1:0] prod, acc, prod_sh;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;

  logic signed [31:0] id, iq, e_d, e_q, es_d, es_q, inner_d, inner_q;
  logic signed [31:0] u_d, u_q, us_d, us_q, u_new, va, vb, ta, tb;
  logic [15:0]        duty_a;

  assign angle_idx = smp.elec_angle[15 -: SINE_TABLE_BITS];
  assign rom_index = (state == foc_cl_pkg::ST_ROM_COS) ?
                     angle_idx + SINE_TABLE_BITS'(QUARTER) : angle_idx;

  foc_cl_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_rom (
    .clk   (clk),
    .index (rom_index),
    .value (rom_value)
  );

  foc_cl_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign prod_sh = prod >>> 16;
  assign e_d = foc_cl_pkg::sat32(SW'(smp.d_setpoint) - SW'(id));
  assign e_q = foc_cl_pkg::sat32(SW'(smp.q_setpoint) - SW'(iq));
  assign u_new = foc_cl_pkg::sat32(SW'((state == foc_cl_pkg::ST_PROP_Q) ?
                 d_prev_clamped_out : q_prev_clamped_out) + SW'(prod_sh));

  assign sample_ready = (state == foc_cl_pkg::ST_IDLE);

  // sequencer and operand selection
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    state_next = state;
    case (state)
      foc_cl_pkg::ST_IDLE:    if (sample_valid) state_next = foc_cl_pkg::ST_ROM_SIN;
      foc_cl_pkg::ST_ROM_SIN: state_next = foc_cl_pkg::ST_ROM_COS;
      foc_cl_pkg::ST_ROM_COS: state_next = foc_cl_pkg::ST_TRIG;
      foc_cl_pkg::ST_TRIG:    state_next = foc_cl_pkg::ST_ID_A;
      foc_cl_pkg::ST_ID_A: begin
        mul_a = AW'(smp.phase_a_current); mul_b = BW'(cos_v);
        state_next = foc_cl_pkg::ST_ID_B;
      end
      foc_cl_pkg::ST_ID_B: begin
        mul_a = AW'(smp.phase_b_current); mul_b = BW'(sin_v);
        state_next = foc_cl_pkg::ST_IQ_A;
      end
      foc_cl_pkg::ST_IQ_A: begin
        mul_a = AW'(smp.phase_b_current); mul_b = BW'(cos_v);
        state_next = foc_cl_pkg::ST_IQ_B;
      end
      foc_cl_pkg::ST_IQ_B: begin
        mul_a = AW'(smp.phase_a_current); mul_b = BW'(sin_v);
        state_next = foc_cl_pkg::ST_ES_D;
      end
      foc_cl_pkg::ST_ES_D: begin
        mul_a = AW'(d_prev_clamped_out) - AW'(d_prev_raw_out);
        mul_b = $signed({1'b0, antiwindup_gain});
        state_next = foc_cl_pkg::ST_ES_Q;
      end
      foc_cl_pkg::ST_ES_Q: begin
        mul_a = AW'(q_prev_clamped_out) - AW'(q_prev_raw_out);
        mul_b = $signed({1'b0, antiwindup_gain});
        state_next = foc_cl_pkg::ST_INT_D;
      end
      foc_cl_pkg::ST_INT_D: begin
        mul_a = AW'(e_d) + AW'(d_prev_corr_error);
        mul_b = $signed({1'b0, integral_ratio});
        state_next = foc_cl_pkg::ST_INT_Q;
      end
      foc_cl_pkg::ST_INT_Q: begin
        mul_a = AW'(e_q) + AW'(q_prev_corr_error);
        mul_b = $signed({1'b0, integral_ratio});
        state_next = foc_cl_pkg::ST_PROP_D;
      end
      foc_cl_pkg::ST_PROP_D: begin
        mul_a = AW'(inner_d); mul_b = $signed({1'b0, prop_gain});
        state_next = foc_cl_pkg::ST_PROP_Q;
      end
      foc_cl_pkg::ST_PROP_Q: begin
        mul_a = AW'(inner_q); mul_b = $signed({1'b0, prop_gain});
        state_next = foc_cl_pkg::ST_VA_A;
      end
      foc_cl_pkg::ST_VA_A: begin
        mul_a = AW'(us_d); mul_b = BW'(cos_v);
        state_next = foc_cl_pkg::ST_VA_B;
      end
      foc_cl_pkg::ST_VA_B: begin
        mul_a = AW'(us_q); mul_b = BW'(sin_v);
        state_next = foc_cl_pkg::ST_VB_A;
      end
      foc_cl_pkg::ST_VB_A: begin
        mul_a = AW'(us_d); mul_b = BW'(sin_v);
        state_next = foc_cl_pkg::ST_VB_B;
      end
      foc_cl_pkg::ST_VB_B: begin
        mul_a = AW'(us_q); mul_b = BW'(cos_v);
        state_next = foc_cl_pkg::ST_TA;
      end
      foc_cl_pkg::ST_TA: begin
        mul_a = AW'(va); mul_b = $signed({1'b0, inv_supply_volt});
        state_next = foc_cl_pkg::ST_TB;
      end
      foc_cl_pkg::ST_TB: begin
        mul_a = AW'(vb); mul_b = $signed({1'b0, inv_supply_volt});
        state_next = foc_cl_pkg::ST_DA;
      end
      foc_cl_pkg::ST_DA: begin
        mul_a = AW'(ta) + AW'(33'sd65536); mul_b = $signed({16'd0, duty_full});
        state_next = foc_cl_pkg::ST_DB;
      end
      foc_cl_pkg::ST_DB, foc_cl_pkg::ST_DONE: begin
        // done repeats the last product so it holds through a stall
        mul_a = AW'(tb) + AW'(33'sd65536); mul_b = $signed({16'd0, duty_full});
        if (state == foc_cl_pkg::ST_DB) begin
          state_next = foc_cl_pkg::ST_DONE;
        end else if (!result_valid || result_ready) begin
          state_next = foc_cl_pkg::ST_IDLE;
        end
      end
      default: state_next = foc_cl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= foc_cl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain       <= foc_cl_pkg::PROP_GAIN_RST;
      integral_ratio  <= foc_cl_pkg::INTEGRAL_RATIO_RST;
      antiwindup_gain <= foc_cl_pkg::ANTIWINDUP_GAIN_RST;
      volt_upper      <= foc_cl_pkg::VOLT_UPPER_RST;
      volt_lower      <= foc_cl_pkg::VOLT_LOWER_RST;
      inv_supply_volt <= foc_cl_pkg::INV_SUPPLY_VOLT_RST;
      duty_full       <= foc_cl_pkg::DUTY_FULL_RST;
    end else if (cfg_write) begin
      case (foc_cl_pkg::cfg_index_t'(cfg_index))
        foc_cl_pkg::CFG_PROP_GAIN:       prop_gain       <= cfg_data[30:0];
        foc_cl_pkg::CFG_INTEGRAL_RATIO:  integral_ratio  <= cfg_data[30:0];
        foc_cl_pkg::CFG_ANTIWINDUP_GAIN: antiwindup_gain <= cfg_data[30:0];
        foc_cl_pkg::CFG_VOLT_UPPER:      volt_upper      <= cfg_data;
        foc_cl_pkg::CFG_VOLT_LOWER:      volt_lower      <= cfg_data;
        foc_cl_pkg::CFG_INV_SUPPLY_VOLT: inv_supply_volt <= cfg_data[30:0];
        foc_cl_pkg::CFG_DUTY_FULL:       duty_full       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // datapath: each step consumes the product issued one step earlier
  always_ff @(posedge clk) begin
    case (state)
      foc_cl_pkg::ST_IDLE:    if (sample_valid) smp <= sample;
      foc_cl_pkg::ST_ROM_COS: sin_v <= rom_value;
      foc_cl_pkg::ST_TRIG:    cos_v <= rom_value;
      foc_cl_pkg::ST_ID_B:    acc <= prod;
      foc_cl_pkg::ST_IQ_A:    id <= foc_cl_pkg::sat32((SW'(acc) + SW'(prod)) >>> 16);
      foc_cl_pkg::ST_IQ_B:    acc <= prod;
      foc_cl_pkg::ST_ES_D:    iq <= foc_cl_pkg::sat32((SW'(acc) - SW'(prod)) >>> 16);
      foc_cl_pkg::ST_ES_Q:
        es_d <= foc_cl_pkg::sat32(SW'(d_prev_error) + SW'(prod_sh));
      foc_cl_pkg::ST_INT_D:
        es_q <= foc_cl_pkg::sat32(SW'(q_prev_error) + SW'(prod_sh));
      foc_cl_pkg::ST_INT_Q:
        inner_d <= foc_cl_pkg::sat32(SW'(e_d) - SW'(d_prev_corr_error) + SW'(prod_sh));
      foc_cl_pkg::ST_PROP_D:
        inner_q <= foc_cl_pkg::sat32(SW'(e_q) - SW'(q_prev_corr_error) + SW'(prod_sh));
      foc_cl_pkg::ST_PROP_Q: begin
        u_d  <= u_new;
        us_d <= foc_cl_pkg::clamp(u_new, volt_upper, volt_lower);
      end
      foc_cl_pkg::ST_VA_A: begin
        u_q  <= u_new;
        us_q <= foc_cl_pkg::clamp(u_new, volt_upper, volt_lower);
      end
      foc_cl_pkg::ST_VA_B:    acc <= prod;
      foc_cl_pkg::ST_VB_A:    va <= foc_cl_pkg::sat32((SW'(acc) - SW'(prod)) >>> 16);
      foc_cl_pkg::ST_VB_B:    acc <= prod;
      foc_cl_pkg::ST_TA:      vb <= foc_cl_pkg::sat32((SW'(acc) + SW'(prod)) >>> 16);
      foc_cl_pkg::ST_TB:      ta <= foc_cl_pkg::sat32(SW'(prod_sh));
      foc_cl_pkg::ST_DA:      tb <= foc_cl_pkg::sat32(SW'(prod_sh));
      foc_cl_pkg::ST_DB:      duty_a <= foc_cl_pkg::to_duty(prod, duty_full);
      foc_cl_pkg::ST_DONE: begin
        if (!result_valid || result_ready) begin
          result.duty_a <= duty_a;
          result.duty_b <= foc_cl_pkg::to_duty(prod, duty_full);
          result.volt_d <= us_d;
          result.volt_q <= us_q;
        end
      end
      default: ;
    endcase
  end

  // regulator history and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid       <= 1'b0;
      d_prev_error       <= '0;
      d_prev_corr_error  <= '0;
      d_prev_raw_out     <= '0;
      d_prev_clamped_out <= '0;
      q_prev_error       <= '0;
      q_prev_corr_error  <= '0;
      q_prev_raw_out     <= '0;
      q_prev_clamped_out <= '0;
    end else begin
      if (state == foc_cl_pkg::ST_DONE && (!result_valid || result_ready)) begin
        result_valid       <= 1'b1;
        d_prev_error       <= e_d;
        d_prev_corr_error  <= es_d;
        d_prev_raw_out     <= u_d;
        d_prev_clamped_out <= us_d;
        q_prev_error       <= e_q;
        q_prev_corr_error  <= es_q;
        q_prev_raw_out     <= u_q;
        q_prev_clamped_out <= us_q;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

### hdl/foc_cl_checker.sv
`timescale 1ns / 1ps
`include "foc_current_loop_two_phase_unit_macros.svh"

module foc_cl_checker (
  input logic                clk,
  input logic                rst,
  input logic                sample_valid,
  input logic                sample_ready,
  input logic                result_valid,
  input logic                result_ready,
  input foc_cl_pkg::result_t result
);

  // one sample at a time
  `FOC_CL_ASSERT(a_busy_after_accept, sample_valid && sample_ready |=> !sample_ready)

  `FOC_CL_ASSERT(a_stall_holds, result_valid && !result_ready |=> result_valid && $stable(result))

  // a new result only comes out of a busy cycle
  `FOC_CL_ASSERT(a_result_from_busy, $rose(result_valid) |-> $past(!sample_ready))

  `FOC_CL_ASSERT_ALWAYS(a_reset_clears, rst |=> !result_valid)

endmodule

bind foc_current_loop_two_phase_unit foc_cl_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
